// ===== rtl/modbus_reply_crc_checker_top_macros.svh =====
// assertion macros for the modbus reply crc checker
`ifndef MODBUS_REPLY_CRC_CHECKER_TOP_MACROS_SVH
`define MODBUS_REPLY_CRC_CHECKER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, quiet in reset
`define MRCC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mrcc assertion failed");

// next-cycle implication, sampled on clk, quiet in reset
`define MRCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mrcc assertion failed");

`endif

// ===== rtl/mrcc_pkg.sv =====
// types, constants and crc function for the modbus reply crc checker
package mrcc_pkg;

  typedef logic [2:0]  pos_t;
  typedef logic [15:0] crc_t;

  localparam pos_t POS_IDLE   = 3'd7;
  localparam pos_t POS_FIRST  = 3'd0;
  localparam pos_t POS_VAL_HI = 3'd3;
  localparam pos_t POS_VAL_LO = 3'd4;
  localparam pos_t POS_CRC_LO = 3'd5;
  localparam pos_t POS_LAST   = 3'd6;
  localparam pos_t CRC_SPAN   = 3'd5;

  localparam crc_t CRC_INIT = 16'hFFFF;
  localparam crc_t CRC_POLY = 16'hA001;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } item_t;

  typedef struct packed {
    logic [15:0] register_value;
    logic        crc_match;
  } result_t;

  // one byte of crc-16/modbus, reflected, unrolled over eight bits
  function automatic crc_t crc_update(input crc_t crc_in, input logic [7:0] data);
    crc_t c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/mrcc_if.sv =====
// valid/ready channel interfaces for the modbus reply crc checker
interface mrcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface mrcc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] register_value;
  logic        crc_match;

  modport source (output valid, output register_value, output crc_match, input ready);
  modport sink   (input valid, input register_value, input crc_match, output ready);
endinterface

// ===== rtl/mrcc_frame.sv =====
// frame position, running crc and value capture for one reply frame
module mrcc_frame (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  mrcc_pkg::item_t   item,
  output logic              has_result,
  output mrcc_pkg::result_t result
);

  mrcc_pkg::pos_t pos_r;
  mrcc_pkg::pos_t pos_nxt;
  mrcc_pkg::crc_t crc_r;
  mrcc_pkg::crc_t crc_nxt;
  logic [15:0]    value_r;
  logic [15:0]    value_nxt;
  logic [7:0]     crc_lo_r;
  logic [7:0]     crc_lo_nxt;

  mrcc_pkg::pos_t pos_eff;
  mrcc_pkg::crc_t crc_eff;
  logic           active;

  assign pos_eff = item.frame_start ? mrcc_pkg::POS_FIRST : pos_r;
  assign crc_eff = item.frame_start ? mrcc_pkg::CRC_INIT : crc_r;
  assign active  = (pos_eff != mrcc_pkg::POS_IDLE);

  assign has_result            = (pos_eff == mrcc_pkg::POS_LAST);
  assign result.register_value = value_r;
  assign result.crc_match      = (crc_r == {item.rx_byte, crc_lo_r});

  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    value_nxt  = value_r;
    crc_lo_nxt = crc_lo_r;
    if (active) begin
      if (pos_eff < mrcc_pkg::CRC_SPAN) begin
        crc_nxt = mrcc_pkg::crc_update(crc_eff, item.rx_byte);
      end
      unique case (pos_eff)
        mrcc_pkg::POS_VAL_HI: value_nxt  = {item.rx_byte, value_r[7:0]};
        mrcc_pkg::POS_VAL_LO: value_nxt  = {value_r[15:8], item.rx_byte};
        mrcc_pkg::POS_CRC_LO: crc_lo_nxt = item.rx_byte;
        default: ;
      endcase
      if (pos_eff == mrcc_pkg::POS_LAST) begin
        pos_nxt = mrcc_pkg::POS_IDLE;
      end else begin
        pos_nxt = pos_eff + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= mrcc_pkg::POS_IDLE;
      crc_r    <= mrcc_pkg::CRC_INIT;
      value_r  <= '0;
      crc_lo_r <= '0;
    end else if (step) begin
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      value_r  <= value_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

endmodule

// ===== rtl/modbus_reply_crc_checker_top.sv =====
// modbus rtu reply crc checker, top level with input and result registers
//
// in_ch carries received uart bytes of a 7-byte read-register reply, one per
// transaction, with frame_start marking byte 0. out_ch carries one transaction
// per complete frame: the register value from bytes 3 and 4 (high first) and
// crc_match, set when bytes 5 (low) and 6 (high) equal the crc-16/modbus of
// bytes 0 to 4. a frame_start byte always restarts framing; bytes after the
// seventh, or before any frame start, give nothing.
// each byte sits in the input register while the position counter,
// one unrolled byte-wide crc update and the capture logic act on it; a result
// is loaded into the output register as the byte leaves the input register,
// so out_ch.valid rises once the last byte has passed the input register.
// one byte is taken every cycle. when out_ch stalls with a result held, bytes
// that give no result still pass; a byte that would give a result waits in the
// input register and in_ch.ready drops until the output register frees.
// reset (rst_n low at a clock edge) empties both registers and puts the frame
// logic back to waiting for a frame start.
`include "modbus_reply_crc_checker_top_macros.svh"

module modbus_reply_crc_checker_top (
  input  logic       clk,
  input  logic       rst_n,
  mrcc_in_if.sink    in_ch,
  mrcc_out_if.source out_ch
);

  mrcc_pkg::item_t   item_r;
  logic              in_valid_r;
  mrcc_pkg::result_t res_r;
  logic              out_valid_r;

  logic              in_acc;
  logic              out_free;
  logic              s1_adv;
  logic              has_result;
  mrcc_pkg::result_t result;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = in_valid_r && (!has_result || out_free);
  assign in_ch.ready = !in_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.register_value = res_r.register_value;
  assign out_ch.crc_match      = res_r.crc_match;

  mrcc_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_adv),
    .item       (item_r),
    .has_result (has_result),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        in_valid_r <= 1'b1;
      end else if (s1_adv) begin
        in_valid_r <= 1'b0;
      end
      if (s1_adv && has_result) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= '{rx_byte: in_ch.rx_byte, frame_start: in_ch.frame_start};
    end
    if (s1_adv && has_result) begin
      res_r <= result;
    end
  end

  // a finished frame always lands in the result register
  `MRCC_ASSERT_NEXT(a_result_loaded, s1_adv && has_result, out_valid_r)
  // a frame start byte can never close a frame
  `MRCC_ASSERT_NOW(a_start_no_result, in_valid_r && item_r.frame_start, !has_result)
  // a taken result with nothing behind it empties the output register
  `MRCC_ASSERT_NEXT(a_result_drained,
                    out_valid_r && out_ch.ready && !(s1_adv && has_result), !out_valid_r)
  // a byte held in the input register keeps its contents
  `MRCC_ASSERT_NEXT(a_item_held, in_valid_r && !s1_adv, in_valid_r && $stable(item_r))

endmodule
